// ===== rtl/atlb_pkg.sv =====
package atlb_pkg;

  localparam int VA_W     = 64;
  localparam int SID_W    = 16;
  localparam int PERM_W   = 3;
  localparam int STAMP_W  = 32;
  localparam int IDX_W    = 8;
  localparam int PAGE_MAX = 56;
  localparam int PIN_BIT  = 2;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_FLUSH  = 2'd3;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_FAULT = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_FAIL  = 3'd4;

  typedef struct packed {
    logic                valid;
    logic                match;
    logic [IDX_W-1:0]    match_idx;
    logic [PERM_W-1:0]   match_flags;
    logic [PAGE_MAX-1:0] match_phys;
    logic                free;
    logic [IDX_W-1:0]    free_idx;
    logic                lru;
    logic [IDX_W-1:0]    lru_idx;
    logic [STAMP_W-1:0]  lru_stamp;
  } scan_t;

  typedef struct packed {
    logic                wr;
    logic                clr;
    logic                flush;
    logic                stamp_wr;
    logic [IDX_W-1:0]    idx;
    logic [PERM_W-1:0]   flags;
    logic [SID_W-1:0]    space;
    logic [PAGE_MAX-1:0] vpage;
    logic [PAGE_MAX-1:0] ppage;
    logic [STAMP_W-1:0]  stamp;
  } cmd_t;

endpackage

// ===== rtl/atlb_cell.sv =====
module atlb_cell #(
  parameter int IDX = 0,
  parameter int PW  = 52
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [15:0]             sid,
  input  logic [PW-1:0]           vpage,
  input  atlb_pkg::cmd_t          cmd,
  input  atlb_pkg::scan_t         scan_in,
  output atlb_pkg::scan_t         scan_out
);
  import atlb_pkg::*;

  logic [PERM_W-1:0]  flags;
  logic [SID_W-1:0]   space;
  logic [PW-1:0]      vp;
  logic [PW-1:0]      pp;
  logic [STAMP_W-1:0] stamp;
  logic               ent_valid;
  logic               hit;
  logic               sel;
  scan_t              scan_next;
  logic [IDX_W-1:0]   my_idx;

  assign my_idx    = IDX_W'(IDX);
  assign ent_valid = flags != '0;
  assign hit       = ent_valid && space == sid && vp == vpage;
  assign sel       = cmd.idx == my_idx;

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.match && hit) begin
      scan_next.match       = 1'b1;
      scan_next.match_idx   = my_idx;
      scan_next.match_flags = flags;
      scan_next.match_phys  = PAGE_MAX'(pp);
    end
    if (!scan_in.free && !ent_valid) begin
      scan_next.free     = 1'b1;
      scan_next.free_idx = my_idx;
    end
    if (!flags[PIN_BIT] && (!scan_in.lru || stamp < scan_in.lru_stamp)) begin
      scan_next.lru       = 1'b1;
      scan_next.lru_idx   = my_idx;
      scan_next.lru_stamp = stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags          <= '0;
      stamp          <= '0;
      scan_out       <= '0;
    end else begin
      scan_out <= scan_next;
      if (cmd.flush && !flags[PIN_BIT]) begin
        flags <= '0;
      end else if (cmd.clr && sel) begin
        flags <= '0;
      end else if (cmd.wr && sel) begin
        flags <= cmd.flags;
      end
      if (cmd.stamp_wr && sel) begin
        stamp <= cmd.stamp;
      end
    end
    if (cmd.wr && sel) begin
      space <= cmd.space;
      vp    <= cmd.vpage[PW-1:0];
      pp    <= cmd.ppage[PW-1:0];
    end
  end

endmodule

// ===== rtl/assoc_tlb_asid_lru_pinned_top.sv =====
// Fully associative translation table. Pulse start while busy is low to issue one
// request; exactly one result follows, shown for a single cycle with done high and
// status/phys_addr_out valid. The receiver cannot stall it, so capture it then.
// Each request walks a chain of NUM_ENTRIES entry cells, one cell per cycle. done is
// registered from the output of the last cell, and busy drops together with it, so a
// new request can be taken at the edge that ends the done cycle; requests never overlap.
// No clearing pass is needed after reset.
module assoc_tlb_asid_lru_pinned_top #(
  parameter int NUM_ENTRIES = 32,
  parameter int PAGE_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] virt_addr,
  input  logic [15:0] space_id,
  input  logic [2:0]  perm_bits,
  input  logic [63:0] phys_addr_in,
  output logic        done,
  output logic [2:0]  status,
  output logic [63:0] phys_addr_out
);
  import atlb_pkg::*;

  localparam int PW = VA_W - PAGE_BITS;

  logic [1:0]         req_q;
  logic [VA_W-1:0]    va_q;
  logic [SID_W-1:0]   sid_q;
  logic [PERM_W-1:0]  perm_q;
  logic [VA_W-1:0]    pa_q;
  logic               go;
  logic [STAMP_W-1:0] use_counter;
  scan_t              head;
  scan_t              chain [NUM_ENTRIES+1];
  scan_t              r;
  cmd_t               cmd;
  logic               fin;
  logic [2:0]         st_next;
  logic [STAMP_W-1:0] cnt_inc;

  assign cnt_inc = use_counter + 1'b1;

  always_comb begin
    head       = '0;
    head.valid = go;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    atlb_cell #(.IDX(i), .PW(PW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .sid      (sid_q),
      .vpage    (va_q[VA_W-1:PAGE_BITS]),
      .cmd      (cmd),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  assign r   = chain[NUM_ENTRIES];
  assign fin = r.valid;

  always_comb begin
    cmd       = '0;
    cmd.flags = perm_q;
    cmd.space = sid_q;
    cmd.vpage = PAGE_MAX'(va_q[VA_W-1:PAGE_BITS]);
    cmd.ppage = PAGE_MAX'(pa_q[VA_W-1:PAGE_BITS]);
    cmd.stamp = cnt_inc;
    st_next   = ST_DONE;
    case (req_q)
      REQ_LOOKUP: begin
        if (!r.match) begin
          st_next = ST_MISS;
        end else if ((r.match_flags & perm_q) != perm_q) begin
          st_next = ST_FAULT;
        end else begin
          st_next      = ST_HIT;
          cmd.stamp_wr = fin;
          cmd.idx      = r.match_idx;
        end
      end
      REQ_INSERT: begin
        if (perm_q == '0) begin
          st_next = ST_FAIL;
        end else if (r.match) begin
          cmd.wr  = fin;
          cmd.idx = r.match_idx;
        end else if (r.free) begin
          cmd.wr  = fin;
          cmd.idx = r.free_idx;
        end else if (r.lru) begin
          cmd.wr  = fin;
          cmd.idx = r.lru_idx;
        end else begin
          st_next = ST_FAIL;
        end
      end
      REQ_REMOVE: begin
        if (r.match) begin
          cmd.clr = fin;
          cmd.idx = r.match_idx;
        end else begin
          st_next = ST_FAIL;
        end
      end
      REQ_FLUSH: begin
        cmd.flush = fin;
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      go          <= 1'b0;
      done        <= 1'b0;
      use_counter <= '0;
    end else begin
      go   <= 1'b0;
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        go   <= 1'b1;
      end
      if (fin) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (cmd.stamp_wr) begin
          use_counter <= cnt_inc;
        end
      end
    end
    if (start && !busy) begin
      req_q  <= req_type;
      va_q   <= virt_addr;
      sid_q  <= space_id;
      perm_q <= perm_bits;
      pa_q   <= phys_addr_in;
    end
    if (fin) begin
      status        <= st_next;
      phys_addr_out <= (st_next == ST_HIT) ?
                       {r.match_phys[PW-1:0], va_q[PAGE_BITS-1:0]} : '0;
    end
  end

  a_fin_busy: assert property (@(posedge clk) disable iff (rst) fin |-> busy)
    else $error("scan finished while idle");
  a_go_busy: assert property (@(posedge clk) disable iff (rst) go |-> busy)
    else $error("scan launched while idle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> go)
    else $error("accepted item not launched");

endmodule
